@@ design/bgs_pkg.sv @@
package bgs_pkg;

    localparam int MAX_DIMS     = 6;
    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int CELL_W       = 14;
    localparam int MAX_CELLS    = 16384;
    localparam int FRAC_W       = 8;
    localparam int COORD_W      = 16;
    localparam int VALUE_W      = 32;
    localparam int EXT_W        = 8;
    localparam int EXTS_W       = 48;
    localparam int DIM_W        = 3;
    localparam int NCH_W        = 4;
    localparam int CORNER_W     = 7;
    localparam int WGT_W        = 9;
    localparam int IDX_W        = 10;
    localparam int STRIDE_W     = 15;
    localparam int PROD_W       = 42;
    localparam int ACC_W        = 48;
    localparam int ADDR_W       = 17;
    localparam int MEM_DEPTH    = 131072;
    localparam int CFG_ADDR_W   = 2;
    localparam int IN_DATA_W    = 72;
    localparam int OUT_DATA_W   = 40;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_POINT = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DIM_COUNT,
        CFG_CHANNEL_COUNT,
        CFG_HARD_ASSIGNMENT,
        CFG_GRID_EXTENTS
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_AXIS,
        S_CHAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                              is_point;
        logic [CELL_W-1:0]                 cell_idx;
        logic [CH_W-1:0]                   channel;
        logic [VALUE_W-1:0]                value;
        logic [MAX_DIMS-1:0][COORD_W-1:0]  coords;
    } t_cmd;

    typedef struct packed {
        logic [DIM_W-1:0]  dims;
        logic [NCH_W-1:0]  nch;
        logic              hard;
        logic [EXTS_W-1:0] extents;
    } t_cfg;

endpackage

@@ design/bgs_front.sv @@
module bgs_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_action,
    input  logic [bgs_pkg::CELL_W-1:0]  i_cell,
    input  logic [bgs_pkg::CH_W-1:0]    i_channel,
    input  logic [bgs_pkg::VALUE_W-1:0] i_value,
    input  logic [bgs_pkg::COORD_W-1:0] i_coord,
    input  logic                     i_last,
    input  logic                     i_cfg_we,
    input  logic [bgs_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bgs_pkg::EXTS_W-1:0]  i_cfg_wdata,
    input  logic                     i_enable,
    input  logic                     i_full,
    output logic                     o_push,
    output bgs_pkg::t_cmd            o_cmd,
    output bgs_pkg::t_cfg            o_cfg
);

    logic [bgs_pkg::MAX_DIMS-1:0][bgs_pkg::COORD_W-1:0] r_coord, n_coord;
    logic [bgs_pkg::DIM_W-1:0] r_cnt, n_cnt;
    logic [bgs_pkg::DIM_W-1:0] r_dims;
    logic [bgs_pkg::NCH_W-1:0] r_nch;
    logic r_hard;
    logic [bgs_pkg::EXTS_W-1:0] r_ext;
    logic accept;

    assign o_ready = i_enable && !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_coord = r_coord;
        n_cnt   = r_cnt;
        if (accept && i_action == bgs_pkg::ACT_POINT) begin
            if (r_cnt < bgs_pkg::DIM_W'(bgs_pkg::MAX_DIMS)) begin
                n_coord[r_cnt] = i_coord;
                n_cnt = r_cnt + 1'b1;
            end
            if (i_last) begin
                n_cnt = '0;
            end
        end
    end

    assign o_push = accept && (i_action == bgs_pkg::ACT_WRITE || i_last);
    assign o_cmd  = '{is_point: i_action, cell_idx: i_cell, channel: i_channel,
                      value: i_value, coords: n_coord};

    always_ff @(posedge i_clk) begin
        r_coord <= n_coord;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_dims <= 3'd3;
            r_nch  <= 4'd1;
            r_hard <= 1'b0;
            r_ext  <= 48'h1010_1010_1010;
        end else begin
            r_cnt <= n_cnt;
            if (i_cfg_we) begin
                case (bgs_pkg::t_cfg_idx'(i_cfg_addr))
                    bgs_pkg::CFG_DIM_COUNT:       r_dims <= i_cfg_wdata[bgs_pkg::DIM_W-1:0];
                    bgs_pkg::CFG_CHANNEL_COUNT:   r_nch  <= i_cfg_wdata[bgs_pkg::NCH_W-1:0];
                    bgs_pkg::CFG_HARD_ASSIGNMENT: r_hard <= i_cfg_wdata[0];
                    bgs_pkg::CFG_GRID_EXTENTS:    r_ext  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_cfg.hard    = r_hard;
        o_cfg.extents = r_ext;
        o_cfg.dims    = r_dims;
        if (r_dims == '0) begin
            o_cfg.dims = 3'd1;
        end else if (r_dims > bgs_pkg::DIM_W'(bgs_pkg::MAX_DIMS)) begin
            o_cfg.dims = bgs_pkg::DIM_W'(bgs_pkg::MAX_DIMS);
        end
        o_cfg.nch = r_nch;
        if (r_nch == '0) begin
            o_cfg.nch = 4'd1;
        end else if (r_nch > bgs_pkg::NCH_W'(bgs_pkg::MAX_CHANNELS)) begin
            o_cfg.nch = bgs_pkg::NCH_W'(bgs_pkg::MAX_CHANNELS);
        end
    end

endmodule

@@ design/bgs_cmd_fifo.sv @@
module bgs_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bgs_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bgs_pkg::t_cmd o_data
);

    bgs_pkg::t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ design/bgs_back.sv @@
module bgs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bgs_pkg::t_cfg               i_cfg,
    input  logic                        i_q_valid,
    input  bgs_pkg::t_cmd               i_q_data,
    output logic                        o_pop,
    output logic                        o_enable,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bgs_pkg::CH_W-1:0]    o_channel,
    output logic [bgs_pkg::VALUE_W-1:0] o_value,
    output logic                        o_last
);

    localparam int LIN_W = bgs_pkg::CELL_W + bgs_pkg::IDX_W;

    bgs_pkg::t_state r_state, n_state;

    logic [bgs_pkg::VALUE_W-1:0] r_mem [bgs_pkg::MEM_DEPTH];
    logic mem_we;
    logic [bgs_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [bgs_pkg::VALUE_W-1:0] mem_wdata;

    logic [bgs_pkg::ADDR_W-1:0] r_clr, n_clr;
    logic [bgs_pkg::MAX_DIMS-1:0][bgs_pkg::COORD_W-1:0] r_coords, n_coords;
    logic [bgs_pkg::CORNER_W-1:0] r_corner, n_corner;
    logic [bgs_pkg::DIM_W-1:0] r_axis, n_axis;
    logic [bgs_pkg::WGT_W-1:0] r_w, n_w;
    logic [bgs_pkg::CELL_W-1:0] r_lin, n_lin;
    logic [bgs_pkg::STRIDE_W-1:0] r_stride, n_stride;
    logic r_out, n_out;
    logic [bgs_pkg::CH_W-1:0] r_ch, n_ch;
    logic [bgs_pkg::CH_W-1:0] r_ech, n_ech;

    logic r_p1_v, n_p1_v, r_p2_v;
    logic [bgs_pkg::CH_W-1:0] r_p1_ch, r_p2_ch;
    logic [bgs_pkg::WGT_W-1:0] r_p1_w;
    logic signed [bgs_pkg::VALUE_W-1:0] r_rd_data;
    logic signed [bgs_pkg::PROD_W-1:0] r_prod;
    logic signed [bgs_pkg::ACC_W-1:0] r_sum [bgs_pkg::MAX_CHANNELS];
    logic sum_clear;

    logic r_ov;
    logic [bgs_pkg::CH_W-1:0] r_o_ch;
    logic [bgs_pkg::VALUE_W-1:0] r_o_val;
    logic r_o_last;
    logic out_load;

    logic [bgs_pkg::COORD_W-1:0] x;
    logic [bgs_pkg::EXT_W-1:0] ext, n_int, f;
    logic [bgs_pkg::COORD_W:0] x_half;
    logic corner_bit;
    logic signed [bgs_pkg::IDX_W-1:0] idx;
    logic [bgs_pkg::WGT_W-1:0] a, w_new;
    logic [2*bgs_pkg::WGT_W-1:0] w_prod;
    logic [LIN_W-1:0] lin_sum;
    logic [bgs_pkg::STRIDE_W+bgs_pkg::EXT_W-1:0] str_prod;
    logic axis_bad, lin_bad, step_out, last_axis, last_corner, last_ch, last_ech;
    logic [bgs_pkg::CORNER_W-1:0] corners_m1;
    logic signed [bgs_pkg::ACC_W-1:0] rounded;
    logic [bgs_pkg::VALUE_W-1:0] sat_val;

    always_comb begin
        x          = r_coords[r_axis];
        n_int      = x[bgs_pkg::COORD_W-1:bgs_pkg::FRAC_W];
        f          = x[bgs_pkg::FRAC_W-1:0];
        ext        = i_cfg.extents[{r_axis, 3'b000} +: bgs_pkg::EXT_W];
        corner_bit = r_corner[r_axis];
        x_half     = {1'b0, x} + 17'd128;
        if (i_cfg.hard) begin
            idx = $signed({1'b0, x_half[bgs_pkg::COORD_W:bgs_pkg::FRAC_W]}) - 10'sd1;
            a   = 9'd256;
        end else if (corner_bit) begin
            idx = $signed({2'b00, n_int});
            a   = {1'b0, f};
        end else begin
            idx = $signed({2'b00, n_int}) - 10'sd1;
            a   = 9'd256 - {1'b0, f};
        end
        w_prod   = r_w * a + 18'd128;
        w_new    = i_cfg.hard ? r_w : w_prod[16:8];
        axis_bad = idx < 0 || idx[8:0] >= {1'b0, ext};
        lin_sum  = {{bgs_pkg::IDX_W{1'b0}}, r_lin}
                 + LIN_W'(idx[bgs_pkg::EXT_W-1:0]) * LIN_W'(r_stride);
        lin_bad  = lin_sum >= LIN_W'(bgs_pkg::MAX_CELLS);
        str_prod = r_stride * ext;
        step_out = r_out || axis_bad || lin_bad;
        last_axis   = r_axis == i_cfg.dims - 3'd1;
        corners_m1  = i_cfg.hard ? '0 : (7'd1 << i_cfg.dims) - 7'd1;
        last_corner = r_corner == corners_m1;
        last_ch     = {1'b0, r_ch} == i_cfg.nch - 4'd1;
        last_ech    = {1'b0, r_ech} == i_cfg.nch - 4'd1;
        rounded  = (r_sum[r_ech] + 48'sd128) >>> bgs_pkg::FRAC_W;
        if (rounded > 48'sh0000_7FFF_FFFF) begin
            sat_val = 32'h7FFF_FFFF;
        end else if (rounded < -48'sh0000_8000_0000) begin
            sat_val = 32'h8000_0000;
        end else begin
            sat_val = rounded[bgs_pkg::VALUE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bgs_pkg::S_CLEAR: begin
                if (r_clr == bgs_pkg::ADDR_W'(bgs_pkg::MEM_DEPTH - 1)) begin
                    n_state = bgs_pkg::S_IDLE;
                end
            end
            bgs_pkg::S_IDLE: begin
                if (i_q_valid && i_q_data.is_point) begin
                    n_state = bgs_pkg::S_AXIS;
                end
            end
            bgs_pkg::S_AXIS: begin
                if (last_axis) begin
                    if (!step_out) begin
                        n_state = bgs_pkg::S_CHAN;
                    end else if (last_corner) begin
                        n_state = bgs_pkg::S_DRAIN;
                    end
                end
            end
            bgs_pkg::S_CHAN: begin
                if (last_ch) begin
                    n_state = last_corner ? bgs_pkg::S_DRAIN : bgs_pkg::S_AXIS;
                end
            end
            bgs_pkg::S_DRAIN: begin
                if (!r_p1_v && !r_p2_v) begin
                    n_state = bgs_pkg::S_EMIT;
                end
            end
            bgs_pkg::S_EMIT: begin
                if ((!r_ov || i_ready) && last_ech) begin
                    n_state = bgs_pkg::S_IDLE;
                end
            end
            default: n_state = bgs_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = '0;
        mem_raddr = {r_lin, r_ch};
        sum_clear = 1'b0;
        out_load  = 1'b0;
        n_p1_v    = 1'b0;
        n_clr     = r_clr;
        n_coords  = r_coords;
        n_corner  = r_corner;
        n_axis    = r_axis;
        n_w       = r_w;
        n_lin     = r_lin;
        n_stride  = r_stride;
        n_out     = r_out;
        n_ch      = r_ch;
        n_ech     = r_ech;
        case (r_state)
            bgs_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                n_clr  = r_clr + 1'b1;
            end
            bgs_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (!i_q_data.is_point) begin
                        mem_we    = 1'b1;
                        mem_waddr = {i_q_data.cell_idx, i_q_data.channel};
                        mem_wdata = i_q_data.value;
                    end else begin
                        sum_clear = 1'b1;
                        n_coords  = i_q_data.coords;
                        n_corner  = '0;
                        n_axis    = '0;
                        n_w       = 9'd256;
                        n_lin     = '0;
                        n_stride  = 15'd1;
                        n_out     = 1'b0;
                        n_ch      = '0;
                    end
                end
            end
            bgs_pkg::S_AXIS: begin
                n_w      = w_new;
                n_lin    = lin_sum[bgs_pkg::CELL_W-1:0];
                n_stride = (str_prod >= 23'(bgs_pkg::MAX_CELLS))
                         ? bgs_pkg::STRIDE_W'(bgs_pkg::MAX_CELLS)
                         : str_prod[bgs_pkg::STRIDE_W-1:0];
                n_out    = step_out;
                n_axis   = r_axis + 1'b1;
                n_ch     = '0;
                if (last_axis && step_out && !last_corner) begin
                    n_corner = r_corner + 1'b1;
                    n_axis   = '0;
                    n_w      = 9'd256;
                    n_lin    = '0;
                    n_stride = 15'd1;
                    n_out    = 1'b0;
                end
            end
            bgs_pkg::S_CHAN: begin
                n_p1_v = 1'b1;
                n_ch   = r_ch + 1'b1;
                if (last_ch) begin
                    n_ch = '0;
                    if (!last_corner) begin
                        n_corner = r_corner + 1'b1;
                        n_axis   = '0;
                        n_w      = 9'd256;
                        n_lin    = '0;
                        n_stride = 15'd1;
                        n_out    = 1'b0;
                    end
                end
            end
            bgs_pkg::S_DRAIN: begin
                n_ech = '0;
            end
            bgs_pkg::S_EMIT: begin
                if (!r_ov || i_ready) begin
                    out_load = 1'b1;
                    n_ech    = r_ech + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_coords <= n_coords;
        r_corner <= n_corner;
        r_axis   <= n_axis;
        r_w      <= n_w;
        r_lin    <= n_lin;
        r_stride <= n_stride;
        r_out    <= n_out;
        r_ch     <= n_ch;
        r_ech    <= n_ech;
        r_p1_ch  <= r_ch;
        r_p1_w   <= r_w;
        r_p2_ch  <= r_p1_ch;
        r_prod   <= r_rd_data * $signed({1'b0, r_p1_w});
        if (out_load) begin
            r_o_ch   <= r_ech;
            r_o_val  <= sat_val;
            r_o_last <= last_ech;
        end
        for (int i = 0; i < bgs_pkg::MAX_CHANNELS; i++) begin
            if (sum_clear) begin
                r_sum[i] <= '0;
            end else if (r_p2_v && r_p2_ch == bgs_pkg::CH_W'(i)) begin
                r_sum[i] <= r_sum[i] + bgs_pkg::ACC_W'(r_prod);
            end
        end
        if (!i_rst_n) begin
            r_state <= bgs_pkg::S_CLEAR;
            r_clr   <= '0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_p1_v  <= n_p1_v;
            r_p2_v  <= r_p1_v;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_enable  = r_state != bgs_pkg::S_CLEAR;
    assign o_valid   = r_ov;
    assign o_channel = r_o_ch;
    assign o_value   = r_o_val;
    assign o_last    = r_o_last;

endmodule

@@ design/bilateral_grid_multilinear_slice_unit.sv @@
// A load item is written into the grid store by the back end; a point coordinate without
// the last flag is only collected in the front end. A finished point walks each corner
// (2^dim_count soft, one hard) with dim_count weight/index steps plus channel_count grid
// reads for an in-grid corner, then drains the multiply-accumulate pipeline and emits
// channel_count outputs, for up to six dims and eight channels.
// After reset a clearing pass zeroes every grid store word while no item is accepted.
module bilateral_grid_multilinear_slice_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // cell_index[13:0], channel[16:14], cell_value[48:17], coordinate[64:49], zero pad
    input  logic [71:0] i_s_axis_tdata,
    // action
    input  logic        i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [47:0] i_cfg_wdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_channel[2:0], sliced_value[34:3], zero pad
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    bgs_pkg::t_cmd push_cmd, q_cmd;
    bgs_pkg::t_cfg cfg;
    logic push, full, q_valid, pop, enable;
    logic [bgs_pkg::CH_W-1:0] out_ch;
    logic [bgs_pkg::VALUE_W-1:0] out_val;

    bgs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .i_cell      (i_s_axis_tdata[13:0]),
        .i_channel   (i_s_axis_tdata[16:14]),
        .i_value     (i_s_axis_tdata[48:17]),
        .i_coord     (i_s_axis_tdata[64:49]),
        .i_last      (i_s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_enable    (enable),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_cfg       (cfg)
    );

    bgs_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    bgs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_cmd),
        .o_pop     (pop),
        .o_enable  (enable),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_channel (out_ch),
        .o_value   (out_val),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'b00000, out_val, out_ch};

endmodule
